/* sv/wrr_pkg.sv */
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared types and constants of the weighted round-robin dequeue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package wrr_pkg;

    // Number of queues in service (2 to 8).
    localparam int NUM_QUEUES = 8;

    // Field widths fixed by the item formats.
    localparam int QUEUE_W = 3;
    localparam int MAX_QUEUES = 1 << QUEUE_W;
    localparam int BYTES_W = 32;
    localparam int WEIGHT_W = 8;
    localparam int CFG_REGS = 8;
    localparam int CFG_IDX_W = 3;

    // Input item kinds.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic STATUS_GRANT = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef logic [QUEUE_W-1:0] t_queue;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [MAX_QUEUES-1:0] t_flags;
    typedef logic [MAX_QUEUES-1:0][WEIGHT_W-1:0] t_weights;

    typedef struct packed {
        logic op;
        t_queue queue_select;
        logic [BYTES_W-1:0] queue_bytes;
    } t_in_item;

    typedef struct packed {
        t_queue granted_queue;
        logic status;
    } t_out_item;

    // Outcome of one selection pass.
    typedef struct packed {
        logic found;
        t_queue queue;
        t_queue next_index;
        t_weight next_pending;
    } t_sel_result;

endpackage

`default_nettype wire

/* sv/wrr_in_if.sv */
// ----------------------------------------------------------------------------
// wrr_in_if
// Input channel: queue-size updates and dequeue requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrr_in_if;
    import wrr_pkg::*;

    logic valid;
    logic ready;
    logic op;
    t_queue queue_select;
    logic [BYTES_W-1:0] queue_bytes;

    modport source (output valid, output op, output queue_select, output queue_bytes,
                    input ready);
    modport sink (input valid, input op, input queue_select, input queue_bytes,
                  output ready);
endinterface

`default_nettype wire

/* sv/wrr_out_if.sv */
// ----------------------------------------------------------------------------
// wrr_out_if
// Output channel: grants and rejections.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrr_out_if;
    import wrr_pkg::*;

    logic valid;
    logic ready;
    t_queue granted_queue;
    logic status;

    modport source (output valid, output granted_queue, output status, input ready);
    modport sink (input valid, input granted_queue, input status, output ready);
endinterface

`default_nettype wire

/* sv/weighted_round_robin_dequeue.sv */
// ----------------------------------------------------------------------------
// weighted_round_robin_dequeue
// Weighted round-robin dequeue scheduler over up to eight queues.
// ----------------------------------------------------------------------------
// A request accepted into the input register moves on to the result register
// once that is free or being emptied; a result waits there while the output is
// stalled. Throughput: one item per cycle while the output is not stalled; the
// circular search and weight update run in a single pass between the registers.
// Reset: synchronous, active low; all queues empty, index 0, pending weight one,
// no held request, every weight register one, both pipeline registers empty.
`default_nettype none

module weighted_round_robin_dequeue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [wrr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wrr_pkg::WEIGHT_W-1:0]  i_cfg_data,
    wrr_in_if.sink                             i_in,
    wrr_out_if.source                          o_out
);
    import wrr_pkg::*;

    // Input register stage.
    logic     r_in_valid;
    t_in_item r_in;

    // Result register stage.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // Scheduler state.
    t_flags  r_flags;
    t_queue  r_index;
    t_weight r_pending;
    logic    r_held;

    t_flags  n_flags;
    t_queue  n_index;
    t_weight n_pending;
    logic    n_held;
    logic    n_has_result;

    t_weights    eff_weights;
    t_sel_result sel;

    logic advance;
    logic fire;
    logic in_range;

    // The input stage moves on whenever the result register is free or is
    // being emptied this cycle, so a new request can be taken every cycle.
    // No request is taken while reset is asserted.
    assign advance = !r_out_valid || o_out.ready;
    assign fire = r_in_valid && advance;
    assign i_in.ready = i_rst_n && (!r_in_valid || advance);

    assign o_out.valid = r_out_valid;
    assign o_out.granted_queue = r_out.granted_queue;
    assign o_out.status = r_out.status;

    wrr_weights u_weights (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_eff_weights(eff_weights)
    );

    // The search always sees the flags with this item's update applied.
    wrr_select u_select (
        .i_flags      (n_flags),
        .i_index      (r_index),
        .i_pending    (r_pending),
        .i_eff_weights(eff_weights),
        .o_result     (sel)
    );

    assign in_range = {1'b0, r_in.queue_select} < (QUEUE_W + 1)'(NUM_QUEUES);

    always_comb begin
        n_flags = r_flags;
        n_index = r_index;
        n_pending = r_pending;
        n_held = r_held;
        n_has_result = 1'b0;
        n_out.granted_queue = sel.queue;
        n_out.status = STATUS_GRANT;

        if (r_in.op == OP_UPDATE) begin
            // Updates for queues outside the configured set are dropped.
            if (in_range) begin
                n_flags[r_in.queue_select] = (r_in.queue_bytes != '0);
                // A held request is released as soon as some queue fills.
                // The bit just set guarantees that the search finds a queue.
                if (r_held && r_in.queue_bytes != '0) begin
                    n_index = sel.next_index;
                    n_pending = sel.next_pending;
                    n_held = 1'b0;
                    n_has_result = 1'b1;
                end
            end
        end else if (r_held) begin
            // Only one request can be parked; a second one is turned away
            // without touching the state.
            n_has_result = 1'b1;
            n_out.granted_queue = '0;
            n_out.status = STATUS_REJECT;
        end else begin
            n_index = sel.next_index;
            n_pending = sel.next_pending;
            n_held = !sel.found;
            n_has_result = sel.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.op <= i_in.op;
            r_in.queue_select <= i_in.queue_select;
            r_in.queue_bytes <= i_in.queue_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && n_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_index <= '0;
            r_pending <= t_weight'(1);
            r_held <= 1'b0;
        end else if (fire) begin
            r_flags <= n_flags;
            r_index <= n_index;
            r_pending <= n_pending;
            r_held <= n_held;
        end
    end

    // A request is parked only while every queue is empty.
    a_held_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_flags == '0))
        else $error("held request while a queue is nonempty");

    // The round-robin index never leaves the configured queue range.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_index} < (QUEUE_W + 1)'(NUM_QUEUES))
        else $error("round-robin index out of range");

    // Every grant goes to a queue that is nonempty once the item is applied.
    a_grant_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_has_result && n_out.status == STATUS_GRANT)
            |-> n_flags[n_out.granted_queue])
        else $error("grant issued to an empty queue");

    // A stalled item in the input stage is not lost.
    a_in_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled input item dropped or changed");

endmodule

`default_nettype wire

/* sv/wrr_weights.sv */
// ----------------------------------------------------------------------------
// wrr_weights
// Weight register file; presents the effective weight of every queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wrr_weights (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [wrr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wrr_pkg::WEIGHT_W-1:0]  i_cfg_data,
    output wrr_pkg::t_weights              o_eff_weights
);
    import wrr_pkg::*;

    t_weight r_weight [CFG_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_weight[i] <= t_weight'(1);
            end
        end else if (i_cfg_we) begin
            r_weight[i_cfg_index] <= i_cfg_data;
        end
    end

    // A stored zero acts as a weight of one.
    always_comb begin
        for (int i = 0; i < MAX_QUEUES; i++) begin
            o_eff_weights[i] = (r_weight[i] == '0) ? t_weight'(1) : r_weight[i];
        end
    end
endmodule

`default_nettype wire

/* sv/wrr_select.sv */
// ----------------------------------------------------------------------------
// wrr_select
// Rotating priority search for the next nonempty queue and weight update.
// ----------------------------------------------------------------------------
`default_nettype none

module wrr_select (
    input  wrr_pkg::t_flags      i_flags,
    input  wrr_pkg::t_queue      i_index,
    input  wrr_pkg::t_weight     i_pending,
    input  wrr_pkg::t_weights    i_eff_weights,
    output wrr_pkg::t_sel_result o_result
);
    import wrr_pkg::*;

    localparam int POS_W = QUEUE_W + 1;

    always_comb begin
        t_queue start;
        logic [POS_W-1:0] pos;
        t_weight base;

        if (i_pending == '0) begin
            start = (i_index == t_queue'(NUM_QUEUES - 1)) ? '0 : i_index + t_queue'(1);
        end else begin
            start = i_index;
        end

        // Walk from the far end back so the nearest hit wins.
        o_result.found = 1'b0;
        o_result.queue = '0;
        for (int k = NUM_QUEUES - 1; k >= 0; k--) begin
            pos = {1'b0, start} + POS_W'(k);
            if (pos >= POS_W'(NUM_QUEUES)) begin
                pos = pos - POS_W'(NUM_QUEUES);
            end
            if (i_flags[pos[QUEUE_W-1:0]]) begin
                o_result.found = 1'b1;
                o_result.queue = pos[QUEUE_W-1:0];
            end
        end

        // Leftover weight carries over to whichever queue is found.
        base = (i_pending == '0) ? i_eff_weights[o_result.queue] : i_pending;
        if (o_result.found) begin
            o_result.next_index = o_result.queue;
            o_result.next_pending = base - t_weight'(1);
        end else begin
            o_result.next_index = '0;
            o_result.next_pending = i_eff_weights[0];
        end
    end
endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weighted round-robin dequeue scheduler. A shadow
// scheduler tracks queue occupancy, the round-robin index, the pending weight
// and the held request, and predicts every grant and rejection. Directed tests
// come first, then randomized traffic under several weight settings and
// handshake idle patterns.
// ----------------------------------------------------------------------------

module testbench;
    import wrr_pkg::*;

    // Cycles to wait after the last expected result before the block counts
    // as quiet. The pipeline is two stages deep, so this leaves some margin.
    localparam int QUIET_CYCLES = 8;
    // Longest idle gap the sender inserts before one request.
    localparam int MAX_GAP = 40;
    // Length of the long receiver hold-off in the backpressure test.
    localparam int HOLD_CYCLES = 64;
    // Watchdog: far above the slowest correct run of roughly 1300 requests.
    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WEIGHT_W-1:0]  i_cfg_data;

    wrr_in_if  in_ch ();
    wrr_out_if out_ch ();

    weighted_round_robin_dequeue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // ------------------------------------------------------------------------
    // Shadow scheduler state. It mirrors the block: weight registers, one
    // nonempty flag per queue, the round-robin index, the grants left in the
    // current turn, and whether a dequeue request is parked waiting for data.
    // ------------------------------------------------------------------------
    t_weights shadow_weights;
    t_flags   shadow_nonempty;
    t_queue   shadow_index;
    t_weight  shadow_pending;
    logic     shadow_held;

    // Results the block owes us, oldest first.
    t_out_item expected_grants[$];

    // Bookkeeping for the checker and the closing summary.
    int items_sent;
    int results_seen;
    int mismatches;
    int n_grants;
    int n_rejects;
    int n_holds;
    int n_releases;
    int n_settings;

    // Handshake idle control. The receiver percentage and the hold trigger
    // are written with nonblocking assignments so the receiver process sees
    // them at a well-defined edge.
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_trigger;
    logic hold_seen;
    int   hold_left;

    int cycle_count;

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Watchdog expired after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_grants.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow scheduler. A weight register of zero counts as one grant.
    // ------------------------------------------------------------------------
    function automatic t_weight turn_length(input int q);
        t_weight w;
        w = shadow_weights[q];
        return (w == '0) ? t_weight'(1) : w;
    endfunction

    // One selection pass. When the current turn is used up the search starts
    // one past the index; otherwise it starts at the index itself, so a queue
    // keeps its turn. A leftover pending weight is not reloaded and simply
    // carries over to whatever queue the search lands on. With every queue
    // empty the index and weight fall back to queue 0 and the request parks.
    function automatic bit pick_queue(output t_queue q);
        int start;
        int i;
        start = int'(shadow_index);
        if (shadow_pending == '0) begin
            start++;
            if (start >= NUM_QUEUES)
                start = 0;
        end
        for (int k = 0; k < NUM_QUEUES; k++) begin
            i = (start + k) % NUM_QUEUES;
            if (shadow_nonempty[i]) begin
                shadow_index = t_queue'(i);
                shadow_held = 1'b0;
                if (shadow_pending == '0)
                    shadow_pending = turn_length(i);
                shadow_pending = shadow_pending - t_weight'(1);
                q = t_queue'(i);
                return 1'b1;
            end
        end
        shadow_index = '0;
        shadow_pending = turn_length(0);
        shadow_held = 1'b1;
        q = '0;
        return 1'b0;
    endfunction

    // Applies one accepted request to the shadow state and queues the result
    // it causes, if any.
    function automatic void predict_schedule(input logic op, input t_queue sel,
                                             input logic [BYTES_W-1:0] bytes);
        t_out_item r;
        t_queue    q;
        r.status = STATUS_GRANT;
        if (op == OP_UPDATE) begin
            // Updates naming a queue outside the configured set are dropped.
            if (int'(sel) >= NUM_QUEUES)
                return;
            shadow_nonempty[sel] = (bytes != '0);
            // A parked request is released by the first nonzero size report.
            if (shadow_held && bytes != '0 && pick_queue(q)) begin
                r.granted_queue = q;
                expected_grants.push_back(r);
                n_grants++;
                n_releases++;
            end
            return;
        end
        // A second dequeue while one is parked is turned away untouched.
        if (shadow_held) begin
            r.granted_queue = '0;
            r.status = STATUS_REJECT;
            expected_grants.push_back(r);
            n_rejects++;
            return;
        end
        if (pick_queue(q)) begin
            r.granted_queue = q;
            expected_grants.push_back(r);
            n_grants++;
        end else begin
            n_holds++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every accepted result is compared against the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : grant_checker
        t_out_item seen;
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.granted_queue = out_ch.granted_queue;
            seen.status = out_ch.status;
            results_seen++;
            if (expected_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Cycle %0d: unexpected result queue %0d status %0d",
                             cycle_count, seen.granted_queue, seen.status);
            end else begin
                want = expected_grants.pop_front();
                if (seen.granted_queue !== want.granted_queue
                        || seen.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Cycle %0d: result %0d expected queue %0d status %0d,",
                                 cycle_count, results_seen, want.granted_queue,
                                 want.status);
                        $display("    got queue %0d status %0d",
                                 seen.granted_queue, seen.status);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Ready is randomized at the current idle percentage, except
    // during a long hold-off, which is counted here once the trigger flips.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Valid is left high after a request is taken, so the next call
    // either follows straight on or lowers valid for its idle gap first.
    // Anything that pauses the sender goes through wait_for_quiet, which
    // lowers valid before time moves on.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input t_queue sel,
                                input logic [BYTES_W-1:0] bytes);
        int idle;
        idle = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct && idle < MAX_GAP)
            idle++;
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.queue_select <= sel;
        in_ch.queue_bytes <= bytes;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
        predict_schedule(op, sel, bytes);
    endtask

    // Dequeue requests carry don't-care select and size fields; they are
    // randomized so those bits toggle too.
    task automatic send_dequeue();
        send_request(OP_DEQUEUE, t_queue'($urandom), $urandom);
    endtask

    // Nonzero queue size, biased toward the edges of the 32-bit range.
    function automatic logic [BYTES_W-1:0] pick_size();
        logic [BYTES_W-1:0] v;
        case ($urandom_range(7))
            0: v = '1;
            1: v = 32'h0000_0001;
            2: v = 32'h8000_0000;
            default: begin
                v = $urandom;
                if (v == '0)
                    v = 32'h0000_0001;
            end
        endcase
        return v;
    endfunction

    // Stops offering requests and waits until every expected result is in,
    // then a few more cycles in case the last request produced nothing and
    // is still moving through the pipeline.
    task automatic wait_for_quiet();
        in_ch.valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Writes all eight weight registers back to back. Only called while quiet.
    task automatic load_weights(input t_weights w);
        for (int i = 0; i < CFG_REGS; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data <= w[i];
            shadow_weights[i] = w[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic t_weights make_weights(input int lo, input int hi);
        t_weights w;
        for (int i = 0; i < MAX_QUEUES; i++)
            w[i] = t_weight'($urandom_range(hi, lo));
        return w;
    endfunction

    // Each weight at one end of its range or the other.
    function automatic t_weights make_edge_weights();
        t_weights w;
        for (int i = 0; i < MAX_QUEUES; i++)
            w[i] = $urandom_range(1) ? t_weight'(255) : t_weight'(1);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Out of reset every queue is empty: the first dequeue parks, the second
    // is rejected, a zero-size report leaves it parked, and a nonzero report
    // releases it with a grant.
    task automatic test_reset_and_hold();
        send_dequeue();
        send_dequeue();
        send_request(OP_UPDATE, t_queue'(5), '0);
        send_request(OP_UPDATE, t_queue'(5), '1);
        send_dequeue();
        wait_for_quiet();
    endtask

    // A weight register holding zero must behave as a single grant per turn.
    task automatic test_zero_weight();
        t_weights w;
        w = shadow_weights;
        w[2] = '0;
        load_weights(w);
        send_request(OP_UPDATE, t_queue'(2), 32'h0000_0001);
        send_dequeue();
        send_dequeue();
        send_dequeue();
        send_request(OP_UPDATE, t_queue'(2), '0);
        wait_for_quiet();
    endtask

    // Size reports at the ends of the field on the first and last queues.
    task automatic test_size_extremes();
        send_request(OP_UPDATE, t_queue'(0), 32'h8000_0000);
        send_request(OP_UPDATE, t_queue'(7), '1);
        send_request(OP_UPDATE, t_queue'(3), 32'h7FFF_FFFF);
        send_dequeue();
        send_dequeue();
        send_dequeue();
        send_request(OP_UPDATE, t_queue'(7), '0);
        send_dequeue();
        wait_for_quiet();
    endtask

    // Unequal weights, including the largest, so turns last several grants
    // and leftover pending weight carries across queues.
    task automatic test_weighted_rounds();
        t_weights w;
        w = make_weights(1, 1);
        w[0] = t_weight'(3);
        w[2] = t_weight'(2);
        w[7] = t_weight'(255);
        load_weights(w);
        send_request(OP_UPDATE, t_queue'(1), 32'h0000_FFFF);
        send_request(OP_UPDATE, t_queue'(2), 32'hFFFF_0000);
        repeat (6) send_dequeue();
        wait_for_quiet();
    endtask

    // All queues full, the receiver holds off for a long stretch while the
    // sender keeps offering dequeues, so the block fills and stalls its
    // input. The sender then pauses until everything has drained.
    task automatic test_output_backpressure();
        int saved_tx;
        saved_tx = tx_idle_pct;
        tx_idle_pct = 0;
        for (int q = 0; q < NUM_QUEUES; q++)
            send_request(OP_UPDATE, t_queue'(q), pick_size());
        hold_trigger <= ~hold_trigger;
        repeat (32) send_dequeue();
        wait_for_quiet();
        tx_idle_pct = saved_tx;
    endtask

    // ------------------------------------------------------------------------
    // Randomized traffic. Most of it is built from short scenarios that push
    // the scheduler through its interesting paths, with some plain noise.
    // ------------------------------------------------------------------------
    task automatic test_mixed_traffic(input t_weights w, input int tx_pct,
                                      input int rx_pct, input int n_items);
        int     stop_at;
        int     kind;
        int     first;
        int     q;
        t_flags fill;
        wait_for_quiet();
        load_weights(w);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                // Short burst of mixed dequeues and size reports.
                repeat ($urandom_range(8, 1)) begin
                    if ($urandom_range(99) < 60)
                        send_dequeue();
                    else
                        send_request(OP_UPDATE, t_queue'($urandom),
                                     ($urandom_range(99) < 35) ? '0 : pick_size());
                end
            end else if (kind < 65) begin
                // Empty every queue, park a dequeue, maybe get one rejected
                // and report a zero size, then release it.
                first = $urandom_range(MAX_QUEUES - 1);
                for (int k = 0; k < NUM_QUEUES; k++) begin
                    q = (first + k) % NUM_QUEUES;
                    if (shadow_nonempty[q])
                        send_request(OP_UPDATE, t_queue'(q), '0);
                end
                send_dequeue();
                if ($urandom_range(1))
                    send_dequeue();
                if ($urandom_range(1))
                    send_request(OP_UPDATE, t_queue'($urandom), '0);
                send_request(OP_UPDATE, t_queue'($urandom), pick_size());
            end else if (kind < 90) begin
                // Refill a random set of queues, then serve a run of dequeues.
                fill = t_flags'($urandom_range(255, 1));
                for (int k = 0; k < MAX_QUEUES; k++)
                    if (fill[k])
                        send_request(OP_UPDATE, t_queue'(k), pick_size());
                repeat ($urandom_range(20, 1)) send_dequeue();
            end else begin
                send_request(logic'($urandom), t_queue'($urandom),
                             ($urandom_range(3) == 0) ? '0 : $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_UPDATE;
        in_ch.queue_select = '0;
        in_ch.queue_bytes = '0;
        out_ch.ready = 1'b0;
        hold_trigger = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        tx_idle_pct = 26;
        rx_idle_pct = 63;
        items_sent = 0;
        results_seen = 0;
        mismatches = 0;
        n_grants = 0;
        n_rejects = 0;
        n_holds = 0;
        n_releases = 0;
        n_settings = 0;

        // Shadow copy of the reset state: every weight one, all queues
        // empty, index zero, one grant pending, nothing parked.
        shadow_weights = make_weights(1, 1);
        shadow_nonempty = '0;
        shadow_index = '0;
        shadow_pending = t_weight'(1);
        shadow_held = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_hold();
        test_zero_weight();
        test_size_extremes();
        test_weighted_rounds();
        test_output_backpressure();

        // Sender idles more lightly than the receiver, then the other way
        // round, then neither idles.
        test_mixed_traffic(make_weights(1, 1), 26, 63, 250);
        test_mixed_traffic(make_weights(255, 255), 26, 63, 250);
        test_mixed_traffic(make_weights(1, 255), 63, 26, 250);
        test_mixed_traffic(make_weights(1, 4), 63, 26, 250);
        test_mixed_traffic(make_edge_weights(), 0, 0, 250);

        wait_for_quiet();
        if (expected_grants.size() != 0) begin
            mismatches += expected_grants.size();
            $display("%0d expected results never arrived.", expected_grants.size());
        end

        $display("Sent %0d requests under %0d weight settings: %0d grants, %0d rejections.",
                 items_sent, n_settings, n_grants, n_rejects);
        $display("Requests parked on empty queues: %0d, released by size reports: %0d.",
                 n_holds, n_releases);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches in %0d results.", mismatches, results_seen);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/wrr_pkg.sv
sv/wrr_in_if.sv
sv/wrr_out_if.sv
sv/wrr_weights.sv
sv/wrr_select.sv
sv/weighted_round_robin_dequeue.sv
tb/sv/testbench.sv
